// ----- hdl/aik_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package aik_pkg;

	localparam int GW     = 22;
	localparam int SQW    = 44;
	localparam int RADW   = 50;
	localparam int REMW   = 28;
	localparam int ROOTW  = 25;
	localparam int DREMW  = 38;
	localparam int DENW   = 37;
	localparam int QW     = 25;
	localparam int CWID   = 26;
	localparam int CW     = 48;
	localparam int AW     = 24;
	localparam int ANGW   = 19;
	localparam int CSTEPS = 20;
	localparam int NSQ    = 25;
	localparam int NDIV   = 25;
	localparam int NTERM  = 3;

	localparam logic [RADW-1:0] ONE_SQ = RADW'(1) << 48;
	localparam logic signed [AW-1:0] HALF_PI = 24'sd1647099;

	localparam logic signed [AW-1:0] ATAN_TAB [CSTEPS] = '{
		24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396, 24'sd65451,
		24'sd32757, 24'sd16383, 24'sd8192, 24'sd4096, 24'sd2048,
		24'sd1024, 24'sd512, 24'sd256, 24'sd128, 24'sd64,
		24'sd32, 24'sd16, 24'sd8, 24'sd4, 24'sd2
	};

	typedef enum logic [2:0] {
		REG_OFS_X   = 3'd0,
		REG_OFS_Y   = 3'd1,
		REG_OFS_Z   = 3'd2,
		REG_UPPER   = 3'd3,
		REG_FOREARM = 3'd4,
		REG_HAND    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [RADW-1:0]  rad;
		logic [REMW-1:0]  rem;
		logic [ROOTW-1:0] root;
	} sq_t;

	typedef struct packed {
		logic [DREMW-1:0] rem;
		logic [QW-1:0]    quo;
	} dv_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AW-1:0] acc;
		logic                 zero;
	} cs_t;

	typedef struct packed {
		logic                   bad;
		logic                   neg;
		logic signed [GW-1:0]   gz;
		logic [GW-1:0]          r;
		logic signed [CWID-1:0] c;
	} side_t;

	function automatic cs_t prerot(input logic signed [CW-1:0] y,
			input logic signed [CW-1:0] x);
		cs_t v;
		v.zero = (x == '0) && (y == '0);
		v.x    = x;
		v.y    = y;
		v.acc  = '0;
		if (x[CW-1]) begin
			if (!y[CW-1]) begin
				v.x   = y;
				v.y   = -x;
				v.acc = HALF_PI;
			end else begin
				v.x   = -y;
				v.y   = x;
				v.acc = -HALF_PI;
			end
		end
		return v;
	endfunction

	function automatic cs_t cordic_step(input cs_t v, input logic [4:0] i);
		cs_t n;
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		xs = v.x;
		ys = v.y;
		dx = ys >>> i;
		dy = xs >>> i;
		n  = v;
		if (!ys[CW-1]) begin
			n.x   = xs + dx;
			n.y   = ys - dy;
			n.acc = v.acc + ATAN_TAB[i];
		end else begin
			n.x   = xs - dx;
			n.y   = ys + dy;
			n.acc = v.acc - ATAN_TAB[i];
		end
		return n;
	endfunction

	function automatic logic signed [ANGW-1:0] to_q14(input cs_t v);
		logic [AW-1:0] mag;
		logic [AW-1:0] q;
		mag = v.acc[AW-1] ? AW'(-v.acc) : AW'(v.acc);
		q   = (mag + AW'(32)) >> 6;
		if (v.zero)
			return '0;
		return v.acc[AW-1] ? -$signed(q[ANGW-1:0]) : $signed(q[ANGW-1:0]);
	endfunction

endpackage

`default_nettype wire

// ----- hdl/aik_sqrt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module aik_sqrt_cell import aik_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld_in,
	input  sq_t   d_in,
	input  side_t side_in,
	output logic  vld_out,
	output sq_t   d_out,
	output side_t side_out
);

	logic [REMW-1:0] acc;
	logic [REMW-1:0] trial;
	logic            ge;
	sq_t             nxt;
	logic            vld_q;
	sq_t             d_q;
	side_t           side_q;

	always_comb begin
		acc      = {d_in.rem[REMW-3:0], d_in.rad[RADW-1 -: 2]};
		trial    = {1'b0, d_in.root, 2'b01};
		ge       = acc >= trial;
		nxt.rad  = {d_in.rad[RADW-3:0], 2'b00};
		nxt.rem  = ge ? acc - trial : acc;
		nxt.root = {d_in.root[ROOTW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q    <= nxt;
			side_q <= side_in;
		end
	end

	assign vld_out  = vld_q;
	assign d_out    = d_q;
	assign side_out = side_q;

endmodule

`default_nettype wire

// ----- hdl/aik_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module aik_div_cell import aik_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [DENW-1:0] den,
	input  logic            vld_in,
	input  dv_t             d_in,
	input  side_t           side_in,
	output logic            vld_out,
	output dv_t             d_out,
	output side_t           side_out
);

	logic             ge;
	logic [DREMW-1:0] r1;
	dv_t              nxt;
	logic             vld_q;
	dv_t              d_q;
	side_t            side_q;

	always_comb begin
		ge      = d_in.rem >= {1'b0, den};
		r1      = ge ? d_in.rem - {1'b0, den} : d_in.rem;
		nxt.rem = {r1[DREMW-2:0], 1'b0};
		nxt.quo = {d_in.quo[QW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q    <= nxt;
			side_q <= side_in;
		end
	end

	assign vld_out  = vld_q;
	assign d_out    = d_q;
	assign side_out = side_q;

endmodule

`default_nettype wire

// ----- hdl/aik_cordic_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module aik_cordic_cell import aik_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [4:0]            step,
	input  logic                  vld_in,
	input  cs_t [NTERM-1:0]       v_in,
	input  side_t                 side_in,
	output logic                  vld_out,
	output cs_t [NTERM-1:0]       v_out,
	output side_t                 side_out
);

	logic            vld_q;
	cs_t [NTERM-1:0] v_q;
	side_t           side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int t = 0; t < NTERM; t++) begin
				v_q[t] <= cordic_step(v_in[t], step);
			end
			side_q <= side_in;
		end
	end

	assign vld_out  = vld_q;
	assign v_out    = v_q;
	assign side_out = side_q;

endmodule

`default_nettype wire

// ----- hdl/arm_inverse_kinematics_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Two-link planar arm solver. One goal point is accepted every clock while the spare
// output entry is empty. The pipeline is made of three bit-per-cell chains (25 cells
// for the reach root, 25 for the elbow cosine quotient, 25 for the elbow sine root)
// and 20 vectoring rotation cells, plus six arithmetic and output stages. The output
// holds two results, so a second result is caught while the first waits.
// Register writes must only be made while no goal is in flight.

module arm_inverse_kinematics_core import aik_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // goal_x[19:0], goal_y[39:20], goal_z[59:40], zero fill
	input  logic [0:0]  s_tuser,  // right_side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // shoulder_angle[18:0], elbow_angle[37:19], zero fill
	output logic [0:0]  m_tuser,  // reachable
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [19:0] wr_data
);

	logic signed [19:0] ofs_x_q, ofs_y_q, ofs_z_q;
	logic [16:0]        upper_q, forearm_q, hand_q;
	logic [17:0]        l2;
	logic [33:0]        l1sq_q;
	logic [35:0]        l2sq_q;
	logic [DENW-1:0]    den_q;

	logic adv;

	logic signed [19:0]   goal_x, goal_y, goal_z;
	logic signed [GW-1:0] oy_eff;

	logic                 vld_s1;
	logic signed [GW-1:0] gx_s1, gy_s1, gz_s1;
	logic                 vld_s2;
	logic signed [SQW-1:0] gxsq_s2, gysq_s2;
	logic signed [GW-1:0]  gz_s2;
	logic signed [SQW:0]   r2;

	logic  sa_vld [NSQ+1];
	sq_t   sa_d   [NSQ+1];
	side_t sa_sd  [NSQ+1];
	side_t sa_last;

	logic                  vld_s3;
	logic [SQW-1:0]        rsq_s3;
	logic signed [SQW-1:0] gzsq_s3;
	side_t                 sd_s3;

	logic signed [47:0] num;
	logic [47:0]        mag;

	logic  dv_vld [NDIV+1];
	dv_t   dv_d   [NDIV+1];
	side_t dv_sd  [NDIV+1];
	side_t dv_last;

	logic                   vld_s4;
	logic [2*QW-1:0]        qsq_s4;
	side_t                  sd_s4;

	logic  sb_vld [NSQ+1];
	sq_t   sb_d   [NSQ+1];
	side_t sb_sd  [NSQ+1];

	logic                 vld_s5;
	logic [42:0]          l2s_s5;
	logic signed [44:0]   l2c_s5;
	logic [ROOTW-1:0]     s_s5;
	side_t                sd_s5;

	logic            co_vld [CSTEPS+1];
	cs_t [NTERM-1:0] co_v   [CSTEPS+1];
	side_t           co_sd  [CSTEPS+1];

	logic signed [ANGW-1:0] t0, t1, t2;
	logic [39:0]            res_data;
	logic                   res_reach;

	logic        out_vld_q, skid_vld_q;
	logic [39:0] out_data_q, skid_data_q;
	logic        out_reach_q, skid_reach_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_x_q   <= '0;
			ofs_y_q   <= '0;
			ofs_z_q   <= '0;
			upper_q   <= 17'd16384;
			forearm_q <= 17'd16384;
			hand_q    <= 17'd4096;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_OFS_X:   ofs_x_q   <= wr_data;
				REG_OFS_Y:   ofs_y_q   <= wr_data;
				REG_OFS_Z:   ofs_z_q   <= wr_data;
				REG_UPPER:   upper_q   <= wr_data[16:0];
				REG_FOREARM: forearm_q <= wr_data[16:0];
				REG_HAND:    hand_q    <= wr_data[16:0];
				default: ;
			endcase
		end
	end

	assign l2 = {1'b0, forearm_q} + {1'b0, hand_q};

	always_ff @(posedge clk) begin
		l1sq_q <= upper_q * upper_q;
		l2sq_q <= l2 * l2;
		den_q  <= DENW'({35'(upper_q) * 35'(l2), 1'b0});
	end

	assign adv      = !skid_vld_q;
	assign s_tready = adv;

	assign goal_x = s_tdata[19:0];
	assign goal_y = s_tdata[39:20];
	assign goal_z = s_tdata[59:40];
	assign oy_eff = s_tuser[0] ? -GW'(ofs_y_q) : GW'(ofs_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= sa_vld[NSQ];
			vld_s4 <= dv_vld[NDIV];
			vld_s5 <= sb_vld[NSQ];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gx_s1 <= GW'(goal_x) - GW'(ofs_x_q);
			gy_s1 <= GW'(goal_y) - oy_eff;
			gz_s1 <= GW'(goal_z) - GW'(ofs_z_q);

			gxsq_s2 <= gx_s1 * gx_s1;
			gysq_s2 <= gy_s1 * gy_s1;
			gz_s2   <= gz_s1;
		end
	end

	// Horizontal reach root.
	assign r2 = gxsq_s2 + gysq_s2;

	always_comb begin
		sa_vld[0]     = vld_s2;
		sa_d[0].rad   = RADW'(r2[SQW-1:0]);
		sa_d[0].rem   = '0;
		sa_d[0].root  = '0;
		sa_sd[0].bad  = 1'b0;
		sa_sd[0].neg  = 1'b0;
		sa_sd[0].gz   = gz_s2;
		sa_sd[0].r    = '0;
		sa_sd[0].c    = '0;
	end

	for (genvar k = 0; k < NSQ; k++) begin : g_sqa
		aik_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.vld_in   (sa_vld[k]),
			.d_in     (sa_d[k]),
			.side_in  (sa_sd[k]),
			.vld_out  (sa_vld[k+1]),
			.d_out    (sa_d[k+1]),
			.side_out (sa_sd[k+1])
		);
	end

	always_comb begin
		sa_last   = sa_sd[NSQ];
		sa_last.r = sa_d[NSQ].root[GW-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsq_s3  <= sa_d[NSQ].root[GW-1:0] * sa_d[NSQ].root[GW-1:0];
			gzsq_s3 <= sa_sd[NSQ].gz * sa_sd[NSQ].gz;
			sd_s3   <= sa_last;
		end
	end

	// Law of cosines numerator and reach check.
	always_comb begin
		num = $signed(48'(rsq_s3)) + 48'(gzsq_s3) - $signed(48'(l1sq_q))
			- $signed(48'(l2sq_q));
		mag = num[47] ? 48'(-num) : 48'(num);
		dv_vld[0]     = vld_s3;
		dv_d[0].rem   = mag[DREMW-1:0];
		dv_d[0].quo   = '0;
		dv_sd[0]      = sd_s3;
		dv_sd[0].neg  = num[47];
		dv_sd[0].bad  = (den_q == '0) || (mag > 48'(den_q));
	end

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		aik_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.den      (den_q),
			.vld_in   (dv_vld[k]),
			.d_in     (dv_d[k]),
			.side_in  (dv_sd[k]),
			.vld_out  (dv_vld[k+1]),
			.d_out    (dv_d[k+1]),
			.side_out (dv_sd[k+1])
		);
	end

	always_comb begin
		dv_last   = dv_sd[NDIV];
		dv_last.c = dv_sd[NDIV].neg ? -$signed({1'b0, dv_d[NDIV].quo})
			: $signed({1'b0, dv_d[NDIV].quo});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qsq_s4  <= dv_d[NDIV].quo * dv_d[NDIV].quo;
			sd_s4   <= dv_last;
		end
	end

	// Elbow sine root.
	always_comb begin
		sb_vld[0]    = vld_s4;
		sb_d[0].rad  = ONE_SQ - qsq_s4;
		sb_d[0].rem  = '0;
		sb_d[0].root = '0;
		sb_sd[0]     = sd_s4;
	end

	for (genvar k = 0; k < NSQ; k++) begin : g_sqb
		aik_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.vld_in   (sb_vld[k]),
			.d_in     (sb_d[k]),
			.side_in  (sb_sd[k]),
			.vld_out  (sb_vld[k+1]),
			.d_out    (sb_d[k+1]),
			.side_out (sb_sd[k+1])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			l2s_s5 <= l2 * sb_d[NSQ].root;
			l2c_s5 <= $signed({1'b0, l2}) * sb_sd[NSQ].c;
			s_s5   <= sb_d[NSQ].root;
			sd_s5  <= sb_sd[NSQ];
		end
	end

	// Three vectoring rotations run side by side.
	always_comb begin
		co_vld[0]   = vld_s5;
		co_sd[0]    = sd_s5;
		co_v[0][0]  = prerot($signed(CW'(s_s5)), CW'(sd_s5.c));
		co_v[0][1]  = prerot(CW'(sd_s5.gz), $signed(CW'(sd_s5.r)));
		co_v[0][2]  = prerot($signed(CW'(l2s_s5)),
			$signed(CW'({upper_q, 24'b0})) + CW'(l2c_s5));
	end

	for (genvar k = 0; k < CSTEPS; k++) begin : g_cor
		aik_cordic_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.step     (5'(k)),
			.vld_in   (co_vld[k]),
			.v_in     (co_v[k]),
			.side_in  (co_sd[k]),
			.vld_out  (co_vld[k+1]),
			.v_out    (co_v[k+1]),
			.side_out (co_sd[k+1])
		);
	end

	always_comb begin
		t0        = to_q14(co_v[CSTEPS][0]);
		t1        = to_q14(co_v[CSTEPS][1]);
		t2        = to_q14(co_v[CSTEPS][2]);
		res_reach = !co_sd[CSTEPS].bad;
		res_data  = res_reach ? {2'b00, t0, ANGW'(t1 - t2)} : '0;
	end

	// Two-entry output buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (m_tready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (!out_vld_q || m_tready) begin
			out_vld_q <= co_vld[CSTEPS];
		end else if (co_vld[CSTEPS]) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (m_tready) begin
				out_data_q  <= skid_data_q;
				out_reach_q <= skid_reach_q;
			end
		end else if (!out_vld_q || m_tready) begin
			out_data_q  <= res_data;
			out_reach_q <= res_reach;
		end else begin
			skid_data_q  <= res_data;
			skid_reach_q <= res_reach;
		end
	end

	assign m_tvalid   = out_vld_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_reach_q;

endmodule

`default_nettype wire

// ----- hdl/aik_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module aik_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [0:0]  m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 40'd0)
		else $error("unreachable result carries nonzero angles");

	a_elbow_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tdata[37])
		else $error("negative elbow angle");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

endmodule

bind arm_inverse_kinematics_core aik_checker u_aik_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
